// ----- rtl/assert_macros.svh -----
// Assertion helpers; define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge, masked while in reset.
`define BB3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bb3 assertion failed");

// Checked on every clock edge, reset included.
`define BB3_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bb3 assertion failed");

`else

`define BB3_ASSERT(lbl, prop)
`define BB3_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);   // column index
  localparam int WidthW   = ColW + 1;           // holds MaxWidth itself
  localparam int RowW     = 16;
  localparam int LineSelW = 2;                  // four row slots
  localparam int MemAw    = LineSelW + ColW;
  localparam int NumCh    = 3;
  localparam int ChW      = 8;
  localparam int SumW     = 12;                 // 9 * 255 fits
  localparam int CntW     = 4;                  // pixel count 1..9
  localparam int NumW     = SumW + 1;           // 2*sum + count
  localparam int DenW     = CntW + 1;           // 2*count
  localparam int StepW    = $clog2(NumW);

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;
  localparam int   CfgDataW     = 16;

  typedef logic [NumCh-1:0][ChW-1:0]  rgb_t;    // channel 0 = red
  typedef logic [NumCh-1:0][SumW-1:0] rgb_sum_t;

  // divider request and its answer
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic done;
    rgb_t quot;
  } div_rsp_t;

endpackage

// ----- rtl/bb3_div.sv -----
// Bit-serial restoring divider, three channels sharing one divisor.
// Computes (2*sum + count) / (2*count), one quotient bit per cycle.
module bb3_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bb3_pkg::div_req_t   req_i,
  input  bb3_pkg::rgb_sum_t   sum_i,
  output bb3_pkg::div_rsp_t   rsp_o
);

  logic                                              busy_q, busy_d;
  logic                                              done_q, done_d;
  logic [bb3_pkg::StepW-1:0]                         step_q, step_d;
  logic [bb3_pkg::DenW-1:0]                          den_q, den_d;
  logic [bb3_pkg::NumCh-1:0][bb3_pkg::NumW-1:0]      num_q, num_d;
  logic [bb3_pkg::NumCh-1:0][bb3_pkg::DenW-1:0]      rem_q, rem_d;
  logic [bb3_pkg::NumCh-1:0][bb3_pkg::ChW-1:0]       quot_q, quot_d;
  logic [bb3_pkg::NumCh-1:0][bb3_pkg::DenW:0]        trial;
  logic [bb3_pkg::NumCh-1:0]                         ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    den_d  = den_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    for (int ch = 0; ch < bb3_pkg::NumCh; ch++) begin
      trial[ch] = {rem_q[ch], num_q[ch][bb3_pkg::NumW-1]};
      ge[ch]    = trial[ch] >= {1'b0, den_q};
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = bb3_pkg::StepW'(bb3_pkg::NumW - 1);
      den_d  = {req_i.count, 1'b0};
      for (int ch = 0; ch < bb3_pkg::NumCh; ch++) begin
        num_d[ch] = {sum_i[ch], 1'b0} + bb3_pkg::NumW'(req_i.count);
        rem_d[ch] = '0;
      end
    end else if (busy_q) begin
      for (int ch = 0; ch < bb3_pkg::NumCh; ch++) begin
        rem_d[ch]  = ge[ch] ? bb3_pkg::DenW'(trial[ch] - {1'b0, den_q})
                            : trial[ch][bb3_pkg::DenW-1:0];
        num_d[ch]  = {num_q[ch][bb3_pkg::NumW-2:0], 1'b0};
        quot_d[ch] = {quot_q[ch][bb3_pkg::ChW-2:0], ge[ch]};
      end
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- rtl/box_blur_3x3_edge_clipped.sv -----
// 3x3 box blur with edge clipping over a raster-order RGB stream. Pixels come in
// on the slave stream (tuser = 0) and are written into a 4-row circular store of
// 1024 x 24-bit words held in one synchronous RAM; each output channel is the
// rounded-half-up mean of the in-frame neighbours (9, 6, 4 or fewer pixels).
// An output is produced once the pixel below-right of it (clamped to the frame)
// has been received, so the stream lags the input by about one row. After the
// frame's last pixel, send flush words (tuser = 1) to drain the remaining
// outputs; tlast marks the frame's final output. Pixels arriving while the
// previous frame still drains are dropped and act as flush words. The frame
// size is latched at a frame's first pixel (width 0 acts as 1, above 1024 as
// 1024; height 0 acts as 1). One word is handled at a time: a word that yields
// no output only passes the ready check; one that yields an output reads its
// 1..9 neighbours (4..9 unless the frame is one pixel wide or tall) through
// the single RAM read port (one neighbour per cycle), loads the divider, runs
// the 13-step bit-serial divider until its done strobe, and loads the output
// register once that register has drained. The finished output sits in the
// output register, so the next input word is taken while it waits.
`include "assert_macros.svh"

module box_blur_3x3_edge_clipped (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [23:0]                    s_axis_tdata_i,  // red_in, green_in, blue_in
  input  logic                           s_axis_tuser_i,  // func
  // output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [23:0]                    m_axis_tdata_o,  // red_out, green_out, blue_out
  output logic                           m_axis_tlast_o,  // frame_last
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [bb3_pkg::CfgDataW-1:0]   cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_READ  = 6'b000100,
    ST_ACC   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration and latched frame size
  logic [bb3_pkg::WidthW-1:0] cfg_w_q;
  logic [bb3_pkg::RowW-1:0]   cfg_h_q;
  logic [bb3_pkg::WidthW-1:0] cur_w_q, cur_w_d, usable_w, w_use;
  logic [bb3_pkg::RowW-1:0]   cur_h_q, cur_h_d, usable_h, h_use;

  // input / output raster positions
  logic [bb3_pkg::ColW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [bb3_pkg::RowW-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic                       frame_rcvd_q, frame_rcvd_d;

  // neighbourhood walk
  logic [bb3_pkg::LineSelW-1:0] r_base_q, r_base_d, dr_q, dr_d, nr_m1_q, nr_m1_d;
  logic [bb3_pkg::ColW-1:0]     c_lo_q, c_lo_d;
  logic [1:0]                   dc_q, dc_d, nc_m1_q, nc_m1_d;
  logic [bb3_pkg::CntW-1:0]     count_q, count_d;
  logic                         last_q, last_d;
  logic                         rv_q;
  bb3_pkg::rgb_sum_t            sum_q, sum_d;

  // line store
  logic [23:0]               mem [4*bb3_pkg::MaxWidth];
  logic                      mem_we, mem_re;
  logic [bb3_pkg::MemAw-1:0] wr_addr, rd_addr;
  bb3_pkg::rgb_t             rdata_q;

  // output register
  logic                      out_valid_q, out_valid_d;
  bb3_pkg::rgb_t             out_pix_q;
  logic                      out_last_q;
  logic                      out_load;

  bb3_pkg::div_req_t         div_req;
  bb3_pkg::div_rsp_t         div_rsp;

  logic                      in_acc, is_pix, frame_start;
  logic [bb3_pkg::WidthW-1:0] in_col_inc, out_col_inc, need_c_w;
  logic [bb3_pkg::RowW:0]     in_row_inc, out_row_inc;
  logic [bb3_pkg::RowW-1:0]   need_r, r_lo, r_span;
  logic [bb3_pkg::ColW-1:0]   need_c, c_span, c_lo;
  logic                       ready;
  logic [2:0]                 nr, nc;
  logic [5:0]                 cnt_prod;
  logic [bb3_pkg::WidthW-1:0] in_col_ext;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= bb3_pkg::WidthW'(1024);
      cfg_h_q <= bb3_pkg::RowW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bb3_pkg::CfgIdxWidth:  cfg_w_q <= cfg_data_i[bb3_pkg::WidthW-1:0];
        bb3_pkg::CfgIdxHeight: cfg_h_q <= cfg_data_i[bb3_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q == '0) begin
      usable_w = bb3_pkg::WidthW'(1);
    end else if (cfg_w_q > bb3_pkg::WidthW'(bb3_pkg::MaxWidth)) begin
      usable_w = bb3_pkg::WidthW'(bb3_pkg::MaxWidth);
    end else begin
      usable_w = cfg_w_q;
    end
    usable_h = (cfg_h_q == '0) ? bb3_pkg::RowW'(1) : cfg_h_q;
  end

  // ---------------------------------------------------------------------------
  // Input side: write pixel, advance input position
  // ---------------------------------------------------------------------------
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign is_pix      = in_acc && !s_axis_tuser_i && !frame_rcvd_q;
  assign frame_start = (in_row_q == '0) && (in_col_q == '0);
  assign w_use       = frame_start ? usable_w : cur_w_q;
  assign h_use       = frame_start ? usable_h : cur_h_q;
  assign in_col_inc  = {1'b0, in_col_q} + 1'b1;
  assign in_row_inc  = {1'b0, in_row_q} + 1'b1;

  assign mem_we  = is_pix;
  assign wr_addr = {in_row_q[bb3_pkg::LineSelW-1:0], in_col_q};

  // ---------------------------------------------------------------------------
  // Output readiness: lower-right neighbour, clamped, must be in
  // ---------------------------------------------------------------------------
  assign out_row_inc = {1'b0, out_row_q} + 1'b1;
  assign out_col_inc = {1'b0, out_col_q} + 1'b1;
  assign need_r   = (out_row_inc < {1'b0, cur_h_q}) ? out_row_inc[bb3_pkg::RowW-1:0]
                                                    : cur_h_q - 1'b1;
  assign need_c_w = (out_col_inc < cur_w_q) ? out_col_inc : cur_w_q - 1'b1;
  assign need_c   = need_c_w[bb3_pkg::ColW-1:0];
  assign ready    = frame_rcvd_q || (need_r < in_row_q) ||
                    ((need_r == in_row_q) && (need_c < in_col_q));
  assign r_lo     = (out_row_q == '0) ? '0 : out_row_q - 1'b1;
  assign c_lo     = (out_col_q == '0) ? '0 : out_col_q - 1'b1;
  assign r_span   = need_r - r_lo;
  assign c_span   = need_c - c_lo;
  assign nr       = {1'b0, r_span[1:0]} + 3'd1;
  assign nc       = {1'b0, c_span[1:0]} + 3'd1;
  assign cnt_prod = nr * nc;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    cur_w_d      = cur_w_q;
    cur_h_d      = cur_h_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    frame_rcvd_d = frame_rcvd_q;
    r_base_d     = r_base_q;
    dr_d         = dr_q;
    nr_m1_d      = nr_m1_q;
    c_lo_d       = c_lo;
    dc_d         = dc_q;
    nc_m1_d      = nc_m1_q;
    count_d      = count_q;
    last_d       = last_q;
    mem_re       = 1'b0;
    out_load     = 1'b0;
    div_req      = '{start: 1'b0, count: count_q};

    for (int ch = 0; ch < bb3_pkg::NumCh; ch++) begin
      sum_d[ch] = rv_q ? sum_q[ch] + bb3_pkg::SumW'(rdata_q[ch]) : sum_q[ch];
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CHECK;
          if (is_pix) begin
            cur_w_d = w_use;
            cur_h_d = h_use;
            if (in_col_inc >= w_use) begin
              in_col_d = '0;
              if (in_row_inc >= {1'b0, h_use}) begin
                in_row_d     = '0;
                frame_rcvd_d = 1'b1;
              end else begin
                in_row_d = in_row_inc[bb3_pkg::RowW-1:0];
              end
            end else begin
              in_col_d = in_col_inc[bb3_pkg::ColW-1:0];
            end
          end
        end
      end
      ST_CHECK: begin
        if (!ready) begin
          state_d = ST_IDLE;
        end else begin
          state_d  = ST_READ;
          r_base_d = r_lo[bb3_pkg::LineSelW-1:0];
          nr_m1_d  = r_span[1:0];
          nc_m1_d  = c_span[1:0];
          dr_d     = '0;
          dc_d     = '0;
          count_d  = cnt_prod[bb3_pkg::CntW-1:0];
          sum_d    = '0;
          last_d   = (out_row_q == cur_h_q - 1'b1) &&
                     ({1'b0, out_col_q} == cur_w_q - 1'b1);
          if (last_d) begin
            out_row_d    = '0;
            out_col_d    = '0;
            frame_rcvd_d = 1'b0;
          end else if (out_col_inc >= cur_w_q) begin
            out_col_d = '0;
            out_row_d = out_row_inc[bb3_pkg::RowW-1:0];
          end else begin
            out_col_d = out_col_inc[bb3_pkg::ColW-1:0];
          end
        end
      end
      ST_READ: begin
        // one neighbour per cycle, row-major
        c_lo_d = c_lo_q;
        mem_re = 1'b1;
        if (dc_q == nc_m1_q) begin
          dc_d = '0;
          if (dr_q == nr_m1_q) begin
            state_d = ST_ACC;
          end else begin
            dr_d = dr_q + 1'b1;
          end
        end else begin
          dc_d = dc_q + 1'b1;
        end
      end
      ST_ACC: begin
        // last word lands in sum_d; divider loads from it
        c_lo_d        = c_lo_q;
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        c_lo_d = c_lo_q;
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        c_lo_d = c_lo_q;
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = {r_base_q + dr_q, c_lo_q + bb3_pkg::ColW'(dc_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_w_q      <= bb3_pkg::WidthW'(1024);
      cur_h_q      <= bb3_pkg::RowW'(1024);
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      frame_rcvd_q <= 1'b0;
      rv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_w_q      <= cur_w_d;
      cur_h_q      <= cur_h_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      frame_rcvd_q <= frame_rcvd_d;
      rv_q         <= mem_re;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_base_q <= r_base_d;
    dr_q     <= dr_d;
    nr_m1_q  <= nr_m1_d;
    c_lo_q   <= c_lo_d;
    dc_q     <= dc_d;
    nc_m1_q  <= nc_m1_d;
    count_q  <= count_d;
    last_q   <= last_d;
    sum_q    <= sum_d;
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= s_axis_tdata_i;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  bb3_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sum_i  (sum_d),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q  <= div_rsp.quot;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assign in_col_ext = {1'b0, in_col_q};

  `BB3_ASSERT(a_in_col_in_frame, in_col_ext < cur_w_q)
  `BB3_ASSERT(a_rcvd_at_origin, frame_rcvd_q |-> (in_row_q == '0 && in_col_q == '0))
  `BB3_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == ST_DIV)
  `BB3_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready_i) |-> !out_load)

endmodule

// ----- test/tb_box_blur_3x3_edge_clipped.sv -----
module tb_box_blur_3x3_edge_clipped;

  // About 1.3k words of up to nine neighbours each, plus idling and
  // backpressure on both sides, stay well within this limit.
  localparam int unsigned CycleLimit   = 500_000;
  // Covers the longest word (9 neighbours + divider).
  localparam int          SettleCycles = 40;
  localparam int          RandomPixels = 120;
  localparam int          SteadyPixels = 40;

  typedef struct packed {
    bb3_pkg::rgb_t mean;
    logic          last;
  } blur_word_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [23:0]                  s_axis_tdata_i;   // red_in, green_in, blue_in
  logic                         s_axis_tuser_i;   // func (1 = flush)
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [23:0]                  m_axis_tdata_o;   // red_out, green_out, blue_out
  logic                         m_axis_tlast_o;   // frame_last
  logic                         cfg_we_i;
  logic                         cfg_idx_i;
  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i;

  // Predictor state: register copies, latched frame size, four row slots
  // and the in/out raster positions.
  bb3_pkg::rgb_t row_mem [4][bb3_pkg::MaxWidth];
  int unsigned reg_width, reg_height;
  int unsigned frm_w, frm_h;
  int unsigned wr_col, wr_row, rd_col, rd_row;
  bit          frame_in;          // whole frame received, outputs pending
  blur_word_t  blur_expected[$];

  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned pixel_words, flush_words, words_out, frames_done, frame_px;
  bit          steady;            // no idling on either side while set

  box_blur_3x3_edge_clipped uut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Predictor: one accepted input word, zero or one blurred word out.
  // ---------------------------------------------------------------------
  function automatic void blur_predict(bit flush, bb3_pkg::rgb_t px);
    int unsigned need_r, need_c, r_lo, c_lo, cnt, sum, r, c, ch;
    blur_word_t  w;
    // A pixel while the last frame still drains is dropped (acts as flush).
    if (!flush && !frame_in) begin
      // Frame size is latched at the first pixel; 0 acts as 1, width clamps.
      if (wr_row == 0 && wr_col == 0) begin
        frm_w = (reg_width == 0) ? 1 :
                ((reg_width > bb3_pkg::MaxWidth) ? bb3_pkg::MaxWidth : reg_width);
        frm_h = (reg_height == 0) ? 1 : reg_height;
      end
      row_mem[wr_row % 4][wr_col] = px;
      wr_col++;
      if (wr_col >= frm_w) begin
        wr_col = 0;
        wr_row++;
        if (wr_row >= frm_h) begin
          wr_row   = 0;
          frame_in = 1'b1;
        end
      end
    end
    // Output is ready once its lower-right neighbour (clamped) is in.
    need_r = (rd_row + 1 < frm_h) ? rd_row + 1 : frm_h - 1;
    need_c = (rd_col + 1 < frm_w) ? rd_col + 1 : frm_w - 1;
    if (!(frame_in || need_r < wr_row || (need_r == wr_row && need_c < wr_col))) return;
    r_lo = (rd_row == 0) ? 0 : rd_row - 1;
    c_lo = (rd_col == 0) ? 0 : rd_col - 1;
    cnt  = (need_r - r_lo + 1) * (need_c - c_lo + 1);
    for (ch = 0; ch < bb3_pkg::NumCh; ch++) begin
      sum = 0;
      for (r = r_lo; r <= need_r; r++) begin
        for (c = c_lo; c <= need_c; c++) begin
          sum += row_mem[r % 4][c][ch];
        end
      end
      // round half up: (2*sum + n) / (2*n)
      w.mean[ch] = 8'((2 * sum + cnt) / (2 * cnt));
    end
    w.last = (rd_row == frm_h - 1) && (rd_col == frm_w - 1);
    blur_expected.push_back(w);
    if (w.last) begin
      rd_row   = 0;
      rd_col   = 0;
      frame_in = 1'b0;
      frames_done++;
    end else begin
      rd_col++;
      if (rd_col >= frm_w) begin
        rd_col = 0;
        rd_row++;
      end
    end
  endfunction

  function automatic bb3_pkg::rgb_t rand_pixel();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return '1;   // saturated, worst-case sums
    if (pick < 15) return '0;
    return 24'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Driver side. Inputs move on the falling edge; handshakes are sampled
  // on the rising edge. tvalid stays up after an accept so back-to-back
  // words need no extra assignment in the same step.
  // ---------------------------------------------------------------------
  task automatic send_word(bit flush, bb3_pkg::rgb_t px);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= flush;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    blur_predict(flush, px);
    if (flush) flush_words++;
    else pixel_words++;
  endtask

  // Drop tvalid, wait for every expected word, then let the core settle
  // (a word with no output may still be in flight).
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (blur_expected.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[bb3_pkg::CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bb3_pkg::CfgIdxWidth) reg_width = value & 'h7FF;
    else reg_height = value & 'hFFFF;
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(bb3_pkg::CfgIdxWidth, w);
    write_reg(bb3_pkg::CfgIdxHeight, h);
  endtask

  // Pixels up to and including the frame's last one, with optional stray
  // flushes and register writes mid-frame.
  task automatic send_frame(int unsigned flush_pct, int unsigned write_pct);
    do begin
      if ($urandom_range(99) < flush_pct) send_word(1'b1, rand_pixel());
      if ($urandom_range(99) < write_pct) begin
        if ($urandom_range(1)) write_reg(bb3_pkg::CfgIdxWidth, $urandom_range(0, 16));
        else write_reg(bb3_pkg::CfgIdxHeight, $urandom_range(0, 8));
      end
      send_word(1'b0, rand_pixel());
      frame_px++;
    end while (wr_col != 0 || wr_row != 0);
  endtask

  // Flush until the frame's last output is out; drop_pct of the words are
  // pixels that must be discarded.
  task automatic drain_frame(int unsigned drop_pct);
    while (frame_in) send_word($urandom_range(99) >= drop_pct, rand_pixel());
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random backpressure, then per-field compare on each word.
  // ---------------------------------------------------------------------
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= steady || ($urandom_range(99) >= 33);
    end
  end

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch at word %0d: %s want %0h got %0h", words_out, what, want, got);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    blur_word_t    want;
    bb3_pkg::rgb_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      words_out++;
      got = m_axis_tdata_o;
      if (blur_expected.size() == 0) begin
        report_mismatch("unexpected word", 0, m_axis_tdata_o);
      end else begin
        want = blur_expected.pop_front();
        if (got[0] !== want.mean[0]) report_mismatch("red", want.mean[0], got[0]);
        if (got[1] !== want.mean[1]) report_mismatch("green", want.mean[1], got[1]);
        if (got[2] !== want.mean[2]) report_mismatch("blue", want.mean[2], got[2]);
        if (m_axis_tlast_o !== want.last) report_mismatch("tlast", want.last, m_axis_tlast_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, blur_expected.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Flush straight out of reset: nothing pending, no word comes back.
  task automatic test_idle_flush();
    send_word(1'b1, rand_pixel());
  endtask

  // 3x3 frame: corners, edges and centre all hit, saturated and zero
  // channels mixed. Flush with nothing ready, flush that pops a backlog
  // entry, a dropped pixel while draining, and a flush after the frame.
  task automatic test_square_extremes();
    bb3_pkg::rgb_t sq_px [9];
    int            i;
    sq_px = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hFFFFFF,
              24'h010101, 24'h000000, 24'h80FF7F, 24'hFFFFFF};
    set_size(3, 3);
    for (i = 0; i < 9; i++) begin
      send_word(1'b0, sq_px[i]);
      if (i == 0) send_word(1'b1, '1);   // nothing ready yet
      if (i == 5) send_word(1'b1, '0);   // end of row 1 left one ready
    end
    send_word(1'b0, 24'h5A5AA5);         // frame done: must be dropped
    drain_frame(0);
    send_word(1'b1, rand_pixel());       // nothing left to emit
  endtask

  // Zero width and height both act as 1: a single pixel is its own mean.
  task automatic test_tiny_frame();
    set_size(0, 0);
    send_word(1'b0, 24'hC3A51E);
    send_word(1'b1, rand_pixel());
  endtask

  // Register writes mid-frame (extremes included) must not touch the
  // frame in progress; the last values written apply to the next frame.
  task automatic test_size_latch();
    set_size(3, 2);
    repeat (2) send_word(1'b0, rand_pixel());
    write_reg(bb3_pkg::CfgIdxWidth, bb3_pkg::MaxWidth);
    write_reg(bb3_pkg::CfgIdxHeight, 16'hFFFF);
    send_word(1'b0, rand_pixel());
    set_size(2, 1);
    repeat (3) send_word(1'b0, rand_pixel());
    drain_frame(0);
    send_frame(0, 0);
    drain_frame(0);
  endtask

  // A width above the line buffer depth clamps to it: one full-depth row.
  task automatic test_wide_rows();
    set_size(2047, 1);
    send_frame(2, 0);
    drain_frame(10);
  endtask

  // Mostly small frames with random content; stray flushes, dropped
  // pixels while draining and occasional mid-frame register writes.
  // The opening stretch runs without any idling.
  task automatic test_random_frames();
    int unsigned base, w, h, pick;
    base   = frame_px;
    steady = 1'b1;
    set_size(4, 3);
    while (frame_px - base < RandomPixels) begin
      if (frame_px - base > SteadyPixels) steady = 1'b0;
      if ($urandom_range(3) != 0) begin
        pick = $urandom_range(99);
        if (pick < 5) w = 0;
        else if (pick < 85) w = $urandom_range(1, 8);
        else w = $urandom_range(9, 48);
        h = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
        set_size(w, h);
      end
      send_frame(8, 3);
      drain_frame(15);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = 1'b0;
    s_axis_tdata_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = 1'b0;
    cfg_data_i      = '0;
    steady          = 1'b0;
    // predictor mirrors the reset register values (1024 x 1024)
    reg_width  = bb3_pkg::MaxWidth;
    reg_height = 1024;
    frm_w      = bb3_pkg::MaxWidth;
    frm_h      = 1024;
    wr_col     = 0;
    wr_row     = 0;
    rd_col     = 0;
    rd_row     = 0;
    frame_in   = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_flush();
    test_square_extremes();
    test_tiny_frame();
    test_size_latch();
    test_wide_rows();
    test_random_frames();

    wait_idle();
    $display("sent %0d pixel and %0d flush words over %0d frames (1x1 up to %0d wide)",
             pixel_words, flush_words, frames_done, bb3_pkg::MaxWidth);
    $display("checked %0d blurred words in %0d cycles, %0d mismatches",
             words_out, cycle_count, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
